[rtl/apsp_pkg.sv]
// ----------------------------------------------------------------------------
// apsp_pkg: shared constants and functions for the all-pairs shortest path core
// Data widths, sizes and the saturating add used by the relaxation cells.
// ----------------------------------------------------------------------------
package apsp_pkg;
  localparam int MaxNodesDefault = 8;
  localparam int DistW = 16;
  localparam int CfgW  = 4;
  localparam int IdxW  = 3;
  localparam logic [DistW-1:0] NoPath = 16'hFFFF;

  function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] a,
                                               input logic [DistW-1:0] b);
    logic [DistW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DistW] ? NoPath : s[DistW-1:0];
  endfunction
endpackage

[rtl/apsp_if.sv]
// ----------------------------------------------------------------------------
// apsp_if: valid/ready channel carrying a generic payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface apsp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/apsp_cell.sv]
// ----------------------------------------------------------------------------
// apsp_cell: one relaxation cell of the chain
// Holds a row of the matrix that shifts through the chain, relaxes entries
// against the pivot row, and passes its row to the neighbor each step.
// ----------------------------------------------------------------------------
module apsp_cell #(
  parameter int MaxNodes = apsp_pkg::MaxNodesDefault
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic                         relax,
  input  logic [$clog2(MaxNodes)-1:0]  kidx,
  input  logic [apsp_pkg::DistW-1:0]   pivot [MaxNodes],
  input  logic [apsp_pkg::DistW-1:0]   row_in [MaxNodes],
  output logic [apsp_pkg::DistW-1:0]   row_out [MaxNodes]
);
  logic [apsp_pkg::DistW-1:0] row [MaxNodes];
  logic [apsp_pkg::DistW-1:0] dik;
  assign dik = row[kidx];
  assign row_out = row;

  always_ff @(posedge clk) begin
    for (int j = 0; j < MaxNodes; j++) begin
      if (shift) begin
        row[j] <= row_in[j];
      end else if (relax) begin
        if (row[j] > apsp_pkg::sat_add(dik, pivot[j])) begin
          row[j] <= apsp_pkg::sat_add(dik, pivot[j]);
        end
      end
    end
  end
endmodule

[rtl/all_pairs_shortest_path_core.sv]
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core: Floyd-Warshall over an up to 8x8 matrix
// Chain of row cells; all rows are relaxed together against the pivot row.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : write n_nodes (0 acts as 1, above MaxNodes saturates). A write
//            drops any partial load. Always ready.
//   w_in   : edge weights, row-major, n*n transfers per matrix.
//   d_out  : n*n distances row-major with row/col, last_result on final one.
// Rows live in a ring of MaxNodes cells. Loading shifts a row in every n
// weights. The relax step for pivot k is: rotate the ring once, capturing
// row k as pivot, then every cell relaxes in the same cycle, for each k.
// Output: padding shifts bring row 0 to the head, then one distance per
// cycle when the receiver is ready; the output register holds on stall.
// Input is not accepted during relax or output, so a new matrix is taken
// only after the previous one has fully drained.
// Reset: n_nodes = 8, load count 0, state LOAD.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_core #(
  parameter int MaxNodes = apsp_pkg::MaxNodesDefault
) (
  input logic clk,
  input logic rst,
  apsp_if.sink   cfg,
  apsp_if.sink   w_in,
  apsp_if.source d_out
);
  localparam int RW = $clog2(MaxNodes);
  localparam int DW = apsp_pkg::DistW;

  typedef enum logic [2:0] {
    LOAD  = 3'b001,
    RELAX = 3'b010,
    DRAIN = 3'b100
  } state_t;

  state_t state;
  logic [apsp_pkg::CfgW-1:0] n_nodes;
  logic [RW:0] n_act;
  logic [RW-1:0] ccnt, rcnt, kcnt;   // column, row, pivot counters
  logic [RW:0] rot;                  // rotation position within a pivot
  logic [DW-1:0] rows [MaxNodes+1][MaxNodes];
  logic [DW-1:0] feed [MaxNodes];
  logic [DW-1:0] pbuf [MaxNodes];
  logic shift, relax;

  always_comb begin
    if (n_nodes == '0) n_act = (RW+1)'(1);
    else if (n_nodes > apsp_pkg::CfgW'(MaxNodes)) n_act = (RW+1)'(MaxNodes);
    else n_act = (RW+1)'(n_nodes);
  end

  // ring: the last cell is the head; outside LOAD it feeds back into cell 0
  genvar g;
  generate
    for (g = 0; g < MaxNodes; g++) begin : g_cell
      apsp_cell #(.MaxNodes(MaxNodes)) u_cell (
        .clk(clk), .shift(shift), .relax(relax), .kidx(kcnt),
        .pivot(pbuf), .row_in(rows[g]), .row_out(rows[g+1]));
    end
  endgenerate
  // rows[0] is the input to cell 0: load buffer or wrap-around of last row
  assign rows[0] = feed;

  logic [DW-1:0] lbuf [MaxNodes];
  logic out_v;
  logic [DW-1:0] o_dist;
  logic [RW-1:0] o_row, o_col;
  logic o_last;

  assign cfg.ready  = 1'b1;
  assign w_in.ready = (state == LOAD);
  logic w_fire, o_fire, o_load;
  assign w_fire = w_in.valid && w_in.ready;
  assign o_fire = out_v && d_out.ready;
  // output register takes the next distance of the head row
  assign o_load = (state == DRAIN) && (rot == '0) && (!out_v || d_out.ready) &&
                  !(out_v && o_last);

  // physical ring uses MaxNodes cells; rows beyond n are don't-care fillers
  always_comb begin
    feed = rows[MaxNodes];
    if (state == LOAD) begin
      feed = lbuf;
      feed[ccnt] = w_in.data;
    end
  end

  always_comb begin
    shift = 1'b0;
    relax = 1'b0;
    unique case (state)
      LOAD:  shift = w_fire && !cfg.valid && (ccnt == RW'(n_act - 1));
      RELAX: begin
        shift = (rot < (RW+1)'(MaxNodes));
        relax = !shift;
      end
      // padding shifts, then advance once the last column of a row is taken
      DRAIN: shift = (rot != '0) || (o_load && (ccnt == RW'(n_act - 1)));
      default: ;
    endcase
  end

  // In RELAX: rotate full ring once capturing row k as pivot.
  logic [RW:0] head_pos;  // index of row currently at cell MaxNodes-1
  always_ff @(posedge clk) begin
    if (state == LOAD && w_fire && !cfg.valid) lbuf[ccnt] <= w_in.data;
    if (state == RELAX && shift && (head_pos == (RW+1)'(kcnt)))
      pbuf <= rows[MaxNodes];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD; n_nodes <= 4'd8; ccnt <= '0; rcnt <= '0; kcnt <= '0;
      rot <= '0; out_v <= 1'b0; head_pos <= '0;
    end else if (cfg.valid) begin
      n_nodes <= cfg.data; ccnt <= '0; rcnt <= '0;
    end else begin
      unique case (state)
        LOAD: if (w_fire) begin
          if (ccnt == RW'(n_act - 1)) begin
            ccnt <= '0;
            if (rcnt == RW'(n_act - 1)) begin
              rcnt <= '0; kcnt <= '0; rot <= '0;
              // row 0 sits at cell n-1; head holds row (n - MaxNodes) mod MaxNodes
              head_pos <= (n_act == (RW+1)'(MaxNodes)) ? '0 : n_act;
              state <= RELAX;
            end else rcnt <= rcnt + 1'b1;
          end else ccnt <= ccnt + 1'b1;
        end
        RELAX: begin
          if (shift) begin
            rot <= rot + 1'b1;
            head_pos <= (head_pos == (RW+1)'(MaxNodes - 1)) ? '0 : head_pos + 1'b1;
          end else begin
            rot <= '0;
            if (kcnt == RW'(n_act - 1)) begin
              state <= DRAIN; out_v <= 1'b0; rcnt <= '0; ccnt <= '0;
              rot <= (RW+1)'(MaxNodes) - n_act; // skip padding rows
            end else kcnt <= kcnt + 1'b1;
          end
        end
        DRAIN: begin
          // skip padding so row 0 reaches the head
          if (rot != '0) begin
            rot <= rot - 1'b1;
          end else if (!out_v || d_out.ready) begin
            if (out_v && o_last) begin
              out_v <= 1'b0; state <= LOAD; rcnt <= '0; ccnt <= '0;
            end else begin
              out_v <= 1'b1;
              o_dist <= rows[MaxNodes][ccnt];
              o_row <= rcnt; o_col <= ccnt;
              o_last <= (rcnt == RW'(n_act - 1)) && (ccnt == RW'(n_act - 1));
              if (ccnt == RW'(n_act - 1)) begin
                ccnt <= '0; rcnt <= rcnt + 1'b1;
              end else ccnt <= ccnt + 1'b1;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  assign d_out.valid = out_v;
  assign d_out.data.distance    = o_dist;
  assign d_out.data.row         = 3'(o_row);
  assign d_out.data.col         = 3'(o_col);
  assign d_out.data.last_result = o_last;
endmodule

[tb/tb_all_pairs_shortest_path_core.sv]
// ----------------------------------------------------------------------------
// tb_all_pairs_shortest_path_core: self-checking bench for the APSP core
// Loads weight matrices of several sizes, predicts the relaxed distance
// matrix and checks every distance transfer against it.
// ----------------------------------------------------------------------------
module tb_all_pairs_shortest_path_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxN = apsp_pkg::MaxNodesDefault;
  localparam int SettleCycles = MaxN * (MaxN + 1) + 40;

  typedef logic [apsp_pkg::CfgW-1:0]  cfg_t;
  typedef logic [apsp_pkg::DistW-1:0] weight_t;
  // Distance transfer: distance, row, col, last flag (MSB first).
  typedef struct packed {
    logic [apsp_pkg::DistW-1:0] distance;
    logic [apsp_pkg::IdxW-1:0]  row;
    logic [apsp_pkg::IdxW-1:0]  col;
    logic                       last_result;
  } dist_t;

  logic clk;
  logic rst;

  apsp_if #(.payload_t(cfg_t))    cfg_ch ();
  apsp_if #(.payload_t(weight_t)) w_ch ();
  apsp_if #(.payload_t(dist_t))   d_ch ();

  all_pairs_shortest_path_core dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch.sink),
    .w_in (w_ch.sink),
    .d_out(d_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the matrix, load position and vertex count.
  // ---------------------------------------------------------------------------
  weight_t mat [MaxN*MaxN];
  int      loaded;
  cfg_t    node_reg;
  dist_t   dist_expected [$];
  weight_t weight_pending [$];

  int errors;
  int weights_sent;
  int dists_checked;
  int matrices_done;
  bit no_idle;          // stretches where neither side inserts gaps

  function automatic int active_n();
    int n;
    n = node_reg;
    if (n == 0) n = 1;
    if (n > MaxN) n = MaxN;
    return n;
  endfunction

  // Floyd-Warshall on the local copy, saturating at NoPath.
  function automatic void relax_matrix(int n);
    int s;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          s = int'(mat[i*MaxN+k]) + int'(mat[k*MaxN+j]);
          if (s > int'(apsp_pkg::NoPath)) s = int'(apsp_pkg::NoPath);
          if (int'(mat[i*MaxN+j]) > s) mat[i*MaxN+j] = weight_t'(s);
        end
  endfunction

  // One accepted weight: store it; on the final entry relax and queue results.
  function automatic void load_weight(weight_t w);
    int n;
    int total;
    dist_t d;
    n = active_n();
    total = n * n;
    if (loaded >= total) loaded = 0;
    mat[(loaded / n) * MaxN + (loaded % n)] = w;
    loaded++;
    if (loaded < total) return;
    relax_matrix(n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        d.distance    = mat[i*MaxN+j];
        d.row         = apsp_pkg::IdxW'(i);
        d.col         = apsp_pkg::IdxW'(j);
        d.last_result = (i == n - 1) && (j == n - 1);
        dist_expected.push_back(d);
      end
    loaded = 0;
    matrices_done++;
  endfunction

  task automatic report(string what, dist_t got, dist_t want);
    errors++;
    $display("[%0t] mismatch %s: got d=%0d r=%0d c=%0d l=%0b want d=%0d r=%0d c=%0d l=%0b",
             $realtime, what, got.distance, got.row, got.col, got.last_result,
             want.distance, want.row, want.col, want.last_result);
  endtask

  // ---------------------------------------------------------------------------
  // Weight driver: pops the pending queue, with a random gap after each item.
  // ---------------------------------------------------------------------------
  int w_gap;
  always @(posedge clk) begin
    logic    nxt_valid;
    weight_t nxt_data;
    int      gap;
    if (rst) begin
      w_ch.valid <= 1'b0;
      w_ch.data  <= '0;
      w_gap      <= 0;
    end else begin
      nxt_valid = w_ch.valid;
      nxt_data  = w_ch.data;
      gap       = w_gap;
      if (w_ch.valid && w_ch.ready) begin
        load_weight(w_ch.data);
        weights_sent++;
        nxt_valid = 1'b0;
        gap = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (!nxt_valid) begin
        if (gap > 0) gap--;
        else if (weight_pending.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data  = weight_pending.pop_front();
        end
      end
      w_ch.valid <= nxt_valid;
      w_ch.data  <= nxt_data;
      w_gap      <= gap;
    end
  end

  // ---------------------------------------------------------------------------
  // Distance monitor: random back-pressure, in-order compare per field.
  // ---------------------------------------------------------------------------
  int d_stall;
  always @(posedge clk) begin
    dist_t want;
    int    st;
    if (rst) begin
      d_ch.ready <= 1'b0;
      d_stall    <= 0;
    end else begin
      st = d_stall;
      if (d_ch.valid && d_ch.ready) begin
        dists_checked++;
        if (dist_expected.size() == 0) begin
          report("unexpected transfer", d_ch.data, '0);
        end else begin
          want = dist_expected.pop_front();
          if (d_ch.data.distance !== want.distance) report("distance", d_ch.data, want);
          if (d_ch.data.row !== want.row)           report("row", d_ch.data, want);
          if (d_ch.data.col !== want.col)           report("col", d_ch.data, want);
          if (d_ch.data.last_result !== want.last_result)
            report("last_result", d_ch.data, want);
        end
        st = no_idle ? 0 : $urandom_range(0, 12);
      end else if (st > 0) begin
        st--;
      end
      d_ch.ready <= (st == 0);
      d_stall    <= st;
    end
  end

  // Config transfers update the predictor: new size, partial load dropped.
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      node_reg = cfg_ch.data;
      loaded   = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (weight_pending.size() > 0 || w_ch.valid || dist_expected.size() > 0)
      @(posedge clk);
    // A dropped partial load produces nothing; let the core settle anyway.
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_nodes(cfg_t v);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic weight_t rand_weight();
    case ($urandom_range(0, 5))
      0: return apsp_pkg::NoPath;
      1: return weight_t'($urandom_range(0, 15));
      2: return weight_t'($urandom_range(30000, 65534));
      3: return weight_t'($urandom_range(0, 300));
      default: return weight_t'($urandom);
    endcase
  endfunction

  task automatic push_matrix(int n);
    for (int i = 0; i < n * n; i++) weight_pending.push_back(rand_weight());
  endtask

  initial begin
    int sizes [6];
    rst = 1'b1;
    errors = 0; weights_sent = 0; dists_checked = 0; matrices_done = 0;
    no_idle = 1'b0;
    node_reg = cfg_t'(MaxN);
    loaded = 0;
    foreach (mat[i]) mat[i] = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: count of zero acts as one vertex; weight extremes.
    write_nodes(cfg_t'(0));
    weight_pending.push_back('0);
    weight_pending.push_back(apsp_pkg::NoPath);
    // Two vertices: sum that overflows must saturate, not wrap.
    write_nodes(cfg_t'(2));
    weight_pending.push_back(apsp_pkg::NoPath);
    weight_pending.push_back(weight_t'(40000));
    weight_pending.push_back(weight_t'(40000));
    weight_pending.push_back(apsp_pkg::NoPath);
    // Nonzero diagonal: one entry is kept, the other relaxes through vertex 0.
    weight_pending.push_back(weight_t'(5));
    weight_pending.push_back(weight_t'(3));
    weight_pending.push_back(weight_t'(2));
    weight_pending.push_back(weight_t'(7));
    // Partial load, then a size write discards it.
    write_nodes(cfg_t'(3));
    repeat (4) weight_pending.push_back(weight_t'(16'hAAAA));
    write_nodes(cfg_t'(2));
    weight_pending.push_back(weight_t'(16'h5555));
    weight_pending.push_back(weight_t'(1));
    weight_pending.push_back(weight_t'(1));
    weight_pending.push_back(weight_t'(16'h8000));

    // Random: one full-size matrix via an oversized count, then small sizes.
    write_nodes(cfg_t'(15));
    push_matrix(MaxN);
    sizes = '{1, 3, 4, 2, 5, 3};
    foreach (sizes[p]) begin
      write_nodes(cfg_t'(sizes[p]));
      no_idle = (p % 3 == 1);
      repeat ($urandom_range(0, 1)) push_matrix(sizes[p]);
      // Back-to-back matrices with no size write in between.
      wait_idle();
      push_matrix(sizes[p]);
      if (p == 2) repeat ($urandom_range(1, 4)) weight_pending.push_back(rand_weight());
    end
    write_nodes(cfg_t'(8));
    no_idle = 1'b0;
    push_matrix(3);   // partial 8x8 load, dropped by the next write
    write_nodes(cfg_t'(1));
    push_matrix(1);

    wait_idle();
    repeat (50) @(posedge clk);
    if (dist_expected.size() != 0) errors++;
    $display("Covered %0d weight transfers, %0d matrices, %0d distances checked.",
             weights_sent, matrices_done, dists_checked);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule

[sim.f]
rtl/apsp_pkg.sv
rtl/apsp_if.sv
rtl/apsp_cell.sv
rtl/all_pairs_shortest_path_core.sv
tb/tb_all_pairs_shortest_path_core.sv
